### rtl/core/pan_tilt_aim_pulse_width_defines.svh
// Assertion macros for the pan/tilt aiming block.
// Used by the top level; expects clk and rst in scope.
`ifndef PAN_TILT_AIM_PULSE_WIDTH_DEFINES_SVH
`define PAN_TILT_AIM_PULSE_WIDTH_DEFINES_SVH

// checked outside reset
`define PTAPW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define PTAPW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ptapw_pkg.sv
// Shared types, widths and constants for the pan/tilt aiming block.
// No dependencies.
package ptapw_pkg;

  localparam int CORDIC_STAGES  = 16;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int NUM_CELLS      = (CORDIC_STAGES < ATAN_TABLE_LEN) ? CORDIC_STAGES
                                                                   : ATAN_TABLE_LEN;

  localparam int COORD_W      = 16;
  localparam int GAIN_W       = 16;
  localparam int PULSE_W      = 12;
  localparam int PRE_SCALE    = 16;
  localparam int XY_W         = 36;
  localparam int Z_W          = 25;
  localparam int ATAN_W       = 23;
  localparam int ANG_W        = 23;
  localparam int SHIFT_W      = 5;
  localparam int PROD_W       = ANG_W + GAIN_W;
  localparam int PRODUCT_FRAC = 28;
  localparam int CFG_IDX_W    = 2;

  localparam logic [ANG_W-1:0]   ANGLE_90     = ANG_W'(5898240);
  localparam logic [PULSE_W-1:0] PULSE_CENTER = PULSE_W'(1200);
  localparam logic [PULSE_W-1:0] PULSE_MAX    = PULSE_W'(2639);

  localparam logic [COORD_W-1:0] DIST_RESET = COORD_W'(100);
  localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(36181);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_DISTANCE  = 2'd0,
    REG_PULSE_PER_DEGREE = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ANG_CORDIC,
    ANG_ZERO,
    ANG_RIGHT
  } ang_kind_t;

  typedef struct packed {
    ang_kind_t               kind;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } axis_t;

  typedef struct packed {
    axis_t [1:0] axis;
  } cell_word_t;

  // arctangent of 2^-i in degrees, Q7.16, rounded
  function automatic logic [ATAN_W-1:0] atan_deg_q16(input logic [SHIFT_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = ATAN_W'(2949120);
      5'd1:    v = ATAN_W'(1740967);
      5'd2:    v = ATAN_W'(919879);
      5'd3:    v = ATAN_W'(466945);
      5'd4:    v = ATAN_W'(234379);
      5'd5:    v = ATAN_W'(117304);
      5'd6:    v = ATAN_W'(58666);
      5'd7:    v = ATAN_W'(29335);
      5'd8:    v = ATAN_W'(14668);
      5'd9:    v = ATAN_W'(7334);
      5'd10:   v = ATAN_W'(3667);
      5'd11:   v = ATAN_W'(1833);
      5'd12:   v = ATAN_W'(917);
      5'd13:   v = ATAN_W'(458);
      5'd14:   v = ATAN_W'(229);
      5'd15:   v = ATAN_W'(115);
      5'd16:   v = ATAN_W'(57);
      5'd17:   v = ATAN_W'(29);
      5'd18:   v = ATAN_W'(14);
      5'd19:   v = ATAN_W'(7);
      5'd20:   v = ATAN_W'(4);
      5'd21:   v = ATAN_W'(2);
      5'd22:   v = ATAN_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/ptapw_target_if.sv
// Input channel: one target point per word.
// Depends on ptapw_pkg.
interface ptapw_target_if;
  import ptapw_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  modport source (output valid, output point_x, output point_y, input ready);
  modport sink (input valid, input point_x, input point_y, output ready);
endinterface

### rtl/core/ptapw_pulse_if.sv
// Output channel: two servo pulse widths per word.
// Depends on ptapw_pkg.
interface ptapw_pulse_if;
  import ptapw_pkg::*;
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_x;
  logic [PULSE_W-1:0] pulse_y;
  modport source (output valid, output pulse_x, output pulse_y, input ready);
  modport sink (input valid, input pulse_x, input pulse_y, output ready);
endinterface

### rtl/core/ptapw_cfg_if.sv
// Configuration write channel: register index and data.
// Depends on ptapw_pkg.
interface ptapw_cfg_if;
  import ptapw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [COORD_W-1:0]   reg_data;
  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

### rtl/core/ptapw_cordic_cell.sv
// One vectoring CORDIC iteration for both axes, registered, with handshake.
// Depends on ptapw_pkg.
module ptapw_cordic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ptapw_pkg::SHIFT_W-1:0] shift,
  input  logic [ptapw_pkg::ATAN_W-1:0]  atan_step,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  ptapw_pkg::cell_word_t         up_word,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output ptapw_pkg::cell_word_t         dn_word
);
  import ptapw_pkg::*;

  cell_word_t             word_next;
  logic signed [XY_W-1:0] xs [2];
  logic signed [XY_W-1:0] ys [2];
  logic signed [Z_W-1:0]  step;

  assign step     = $signed({{(Z_W-ATAN_W){1'b0}}, atan_step});
  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    word_next = up_word;
    for (int a = 0; a < 2; a++) begin
      xs[a] = up_word.axis[a].x >>> shift;
      ys[a] = up_word.axis[a].y >>> shift;
      if (!up_word.axis[a].y[XY_W-1] && (up_word.axis[a].y != '0)) begin
        word_next.axis[a].x = up_word.axis[a].x + ys[a];
        word_next.axis[a].y = up_word.axis[a].y - xs[a];
        word_next.axis[a].z = up_word.axis[a].z + step;
      end else begin
        word_next.axis[a].x = up_word.axis[a].x - ys[a];
        word_next.axis[a].y = up_word.axis[a].y + xs[a];
        word_next.axis[a].z = up_word.axis[a].z - step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_word <= word_next;
    end
  end

endmodule

### rtl/core/ptapw_pulse_scale.sv
// Angle clamp, gain multiply and center offset: two registered stages.
// Depends on ptapw_pkg.
module ptapw_pulse_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ptapw_pkg::GAIN_W-1:0]  gain,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  ptapw_pkg::cell_word_t         up_word,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [ptapw_pkg::PULSE_W-1:0] dn_pulse_x,
  output logic [ptapw_pkg::PULSE_W-1:0] dn_pulse_y
);
  import ptapw_pkg::*;

  logic [ANG_W-1:0]   angle [2];
  logic [PROD_W-1:0]  prod_next [2];
  logic [PROD_W-1:0]  prod [2];
  logic               prod_valid;
  logic               prod_ready;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      case (up_word.axis[a].kind)
        ANG_ZERO:  angle[a] = '0;
        ANG_RIGHT: angle[a] = ANGLE_90;
        default: begin
          if (up_word.axis[a].z[Z_W-1]) begin
            angle[a] = '0;
          end else if (up_word.axis[a].z > $signed({{(Z_W-ANG_W){1'b0}}, ANGLE_90})) begin
            angle[a] = ANGLE_90;
          end else begin
            angle[a] = up_word.axis[a].z[ANG_W-1:0];
          end
        end
      endcase
      prod_next[a] = PROD_W'(angle[a]) * PROD_W'(gain);
    end
  end

  assign up_ready   = !prod_valid || prod_ready;
  assign prod_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      dn_valid   <= 1'b0;
    end else begin
      if (up_ready) begin
        prod_valid <= up_valid;
      end
      if (prod_ready) begin
        dn_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod[0] <= prod_next[0];
      prod[1] <= prod_next[1];
    end
    if (prod_ready && prod_valid) begin
      dn_pulse_x <= PULSE_CENTER + PULSE_W'(prod[0][PROD_W-1:PRODUCT_FRAC]);
      dn_pulse_y <= PULSE_CENTER + PULSE_W'(prod[1][PROD_W-1:PRODUCT_FRAC]);
    end
  end

endmodule

### rtl/core/pan_tilt_aim_pulse_width.sv
// Channel    Dir  Word
// target     in   point_x, point_y (16 b each)
// pulse      out  pulse_x, pulse_y (12 b each)
// cfg        in   reg_index (2 b), reg_data (16 b); always ready
//
// One word per cycle sustained while pulse.ready stays high; the word is registered
// in each CORDIC cell, then at clamp/multiply and at center add.
// Ready ripples back combinationally stage by stage; empty stages fill while
// the output word is held, so bubbles collapse under a stall.
// Synchronous reset clears all valid flags and loads the register defaults.
// Top level: config registers, CORDIC cell chain, pulse scaling.
// Depends on ptapw_pkg, the channel interfaces, ptapw_cordic_cell, ptapw_pulse_scale.
`include "pan_tilt_aim_pulse_width_defines.svh"

module pan_tilt_aim_pulse_width (
  input logic clk,
  input logic rst,
  ptapw_target_if.sink   target,
  ptapw_pulse_if.source  pulse,
  ptapw_cfg_if.sink      cfg
);
  import ptapw_pkg::*;

  logic [COORD_W-1:0] screen_distance;
  logic [GAIN_W-1:0]  pulse_per_degree;

  logic       link_valid [NUM_CELLS+1];
  logic       link_ready [NUM_CELLS+1];
  cell_word_t link_word  [NUM_CELLS+1];

  logic [COORD_W-1:0] coord [2];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_distance  <= DIST_RESET;
      pulse_per_degree <= GAIN_RESET;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_SCREEN_DISTANCE:  screen_distance  <= cfg.reg_data;
        REG_PULSE_PER_DEGREE: pulse_per_degree <= cfg.reg_data;
        default: ;
      endcase
    end
  end

  assign coord[0] = target.point_x;
  assign coord[1] = target.point_y;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      link_word[0].axis[a].x = $signed({{(XY_W-COORD_W-PRE_SCALE){1'b0}}, screen_distance,
                                        {PRE_SCALE{1'b0}}});
      link_word[0].axis[a].y = $signed({{(XY_W-COORD_W-PRE_SCALE){1'b0}}, coord[a],
                                        {PRE_SCALE{1'b0}}});
      link_word[0].axis[a].z = '0;
      if (coord[a] == '0) begin
        link_word[0].axis[a].kind = ANG_ZERO;
      end else if (screen_distance == '0) begin
        link_word[0].axis[a].kind = ANG_RIGHT;
      end else begin
        link_word[0].axis[a].kind = ANG_CORDIC;
      end
    end
  end

  assign link_valid[0] = target.valid;
  assign target.ready  = link_ready[0];

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    ptapw_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (SHIFT_W'(k)),
      .atan_step (atan_deg_q16(SHIFT_W'(k))),
      .up_valid  (link_valid[k]),
      .up_ready  (link_ready[k]),
      .up_word   (link_word[k]),
      .dn_valid  (link_valid[k+1]),
      .dn_ready  (link_ready[k+1]),
      .dn_word   (link_word[k+1])
    );
  end

  ptapw_pulse_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .gain       (pulse_per_degree),
    .up_valid   (link_valid[NUM_CELLS]),
    .up_ready   (link_ready[NUM_CELLS]),
    .up_word    (link_word[NUM_CELLS]),
    .dn_valid   (pulse.valid),
    .dn_ready   (pulse.ready),
    .dn_pulse_x (pulse.pulse_x),
    .dn_pulse_y (pulse.pulse_y)
  );

  `PTAPW_ASSERT(a_pulse_range, pulse.valid |-> (pulse.pulse_x >= PULSE_CENTER) && (pulse.pulse_x <= PULSE_MAX) && (pulse.pulse_y >= PULSE_CENTER) && (pulse.pulse_y <= PULSE_MAX), "pulse width out of range")
  `PTAPW_ASSERT(a_chain_hold, link_valid[NUM_CELLS] && !link_ready[NUM_CELLS] |=> link_valid[NUM_CELLS], "word dropped at end of cell chain")
  `PTAPW_ASSERT_ALWAYS(a_reset_empty, rst |=> !pulse.valid && !link_valid[1], "pipeline not empty after reset")

endmodule
